// ===== design/pprj_pkg.sv =====
// Package for the point-to-plane residual and Jacobian pipeline.
// Holds default formats, register codes and the rounding, clamp and saturation helpers.
// No dependencies.
package pprj_pkg;

  localparam int DEF_POS_FRAC_BITS  = 16;
  localparam int DEF_UNIT_FRAC_BITS = 30;
  localparam int MUL_CHUNK          = 16;
  localparam int CFG_IDX_W          = 3;

  typedef logic signed [127:0] wide_t;

  localparam wide_t WIDE_LIM = wide_t'(1) <<< 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INFO_SCALE,
    REG_TRANS_X,
    REG_TRANS_Y,
    REG_TRANS_Z,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_QUAT_W
  } cfg_reg_t;

  // shift right, round to nearest, ties away from zero
  function automatic wide_t rnd_shift(input wide_t p, input int sh);
    wide_t half;
    wide_t adj;
    half = wide_t'(1) <<< (sh - 1);
    adj  = p[127] ? half - wide_t'(1) : half;
    return (p + adj) >>> sh;
  endfunction

  function automatic wide_t clamp_wide(input wide_t x);
    wide_t r;
    r = x;
    if (x > WIDE_LIM) begin
      r = WIDE_LIM;
    end
    if (x < -WIDE_LIM) begin
      r = -WIDE_LIM;
    end
    return r;
  endfunction

  function automatic wide_t rnd_clamp(input wide_t p, input int sh);
    return clamp_wide(rnd_shift(p, sh));
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t x);
    logic signed [31:0] r;
    if (x > wide_t'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (x < wide_t'(-33'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/pprj_dly.sv =====
// Enabled delay line used to align operands with the multiplier stages.
// No dependencies.
module pprj_dly #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ===== design/pprj_mul.sv =====
// Two-stage signed multiplier: partial products by 16-bit digits of b, then their sum.
// Depends on pprj_pkg.
module pprj_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import pprj_pkg::*;

  localparam int NC  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BX  = NC * MUL_CHUNK;
  localparam int PPW = AW + MUL_CHUNK + 1;
  localparam int PW  = AW + BW;

  logic signed [BX-1:0]        b_ext;
  logic signed [MUL_CHUNK:0]   dig [NC];
  logic signed [PPW-1:0]       pp  [NC];
  logic signed [PW-1:0]        acc;

  assign b_ext = BX'(b);

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      dig[k] = {(k == NC - 1) ? b_ext[BX-1] : 1'b0, b_ext[k*MUL_CHUNK +: MUL_CHUNK]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NC; k++) begin
        pp[k] <= a * dig[k];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (PW'(pp[k]) <<< (k * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

// ===== design/point_plane_residual_jacobian.sv =====
// Point-to-plane residual and Jacobian, top level: pose registers and a 13-stage pipeline.
// Depends on pprj_pkg, pprj_mul and pprj_dly.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------------
//   point    | point_valid / point_stall | point_xyz, normal_xyz, plane_offset, weight
//   result   | result_valid/result_stall | residual, jac_trans_xyz, jac_rot_xyz
//   cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle while no result is stalled; an item passes stages 0 to 12 in order.
// The depth is a capture stage and four two-stage multipliers, each followed by a rounding stage.
// A stalled result freezes the whole pipeline and stalls the point channel.
// Synchronous reset empties the pipeline and loads the identity pose and unit scale.
module point_plane_residual_jacobian #(
  parameter int POS_FRAC_BITS  = pprj_pkg::DEF_POS_FRAC_BITS,
  parameter int UNIT_FRAC_BITS = pprj_pkg::DEF_UNIT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pprj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           point_valid,
  output logic                           point_stall,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic signed [31:0]             point_z,
  input  logic signed [31:0]             normal_x,
  input  logic signed [31:0]             normal_y,
  input  logic signed [31:0]             normal_z,
  input  logic signed [31:0]             plane_offset,
  input  logic [30:0]                    point_weight,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [31:0]             residual,
  output logic signed [31:0]             jac_trans_x,
  output logic signed [31:0]             jac_trans_y,
  output logic signed [31:0]             jac_trans_z,
  output logic signed [31:0]             jac_rot_x,
  output logic signed [31:0]             jac_rot_y,
  output logic signed [31:0]             jac_rot_z
);
  import pprj_pkg::*;

  localparam int U   = UNIT_FRAC_BITS;
  localparam int V   = POS_FRAC_BITS;
  localparam int RW  = ((U > 64 - U) ? U : 64 - U) + 3;
  localparam int TW  = (RW + 32 - U > 62) ? 62 : RW + 32 - U;
  localparam int WW  = (((TW > 32) ? TW : 32) + 2 > 62) ? 62 : ((TW > 32) ? TW : 32) + 2;
  localparam int NW  = (WW + 32 - U > 62) ? 62 : WW + 32 - U;
  localparam int DW  = (((NW > 32) ? NW : 32) + 2 > 63) ? 63 : ((NW > 32) ? NW : 32) + 2;
  localparam int MW  = (TW + 2 > 63) ? 63 : TW + 2;
  localparam int CTW = (MW + 32 - U > 62) ? 62 : MW + 32 - U;
  localparam int CW  = (CTW + 1 > 63) ? 63 : CTW + 1;
  localparam int GW  = 64 - V;
  localparam int LAST = 12;

  // pose registers
  logic [30:0]        info_scale;
  logic signed [31:0] trans [3];
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;

  logic              en;
  logic [LAST:0]     vld;

  assign cfg_ready   = 1'b1;
  assign en          = !(vld[LAST] && result_stall);
  assign point_stall = !en;
  assign result_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      info_scale <= 31'(64'd1 << V);
      trans[0]   <= '0;
      trans[1]   <= '0;
      trans[2]   <= '0;
      quat_x     <= '0;
      quat_y     <= '0;
      quat_z     <= '0;
      quat_w     <= 32'(64'd1 << U);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INFO_SCALE: info_scale <= cfg_data[30:0];
        REG_TRANS_X:    trans[0]   <= cfg_data;
        REG_TRANS_Y:    trans[1]   <= cfg_data;
        REG_TRANS_Z:    trans[2]   <= cfg_data;
        REG_QUAT_X:     quat_x     <= cfg_data;
        REG_QUAT_Y:     quat_y     <= cfg_data;
        REG_QUAT_Z:     quat_z     <= cfg_data;
        REG_QUAT_W:     quat_w     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], point_valid};
    end
  end

  // stage 0: capture the item
  logic [2:0][31:0] p0, n0;
  logic signed [31:0] off0;
  logic [30:0]        wgt0;

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= {point_z, point_y, point_x};
      n0   <= {normal_z, normal_y, normal_x};
      off0 <= plane_offset;
      wgt0 <= point_weight;
    end
  end

  // stages 1-2: quaternion pair products and combined scale
  logic signed [31:0] qa [9];
  logic signed [31:0] qb [9];
  logic signed [63:0] qp [9];
  logic signed [63:0] gp;

  always_comb begin
    qa[0] = quat_x; qb[0] = quat_x;
    qa[1] = quat_y; qb[1] = quat_y;
    qa[2] = quat_z; qb[2] = quat_z;
    qa[3] = quat_x; qb[3] = quat_y;
    qa[4] = quat_x; qb[4] = quat_z;
    qa[5] = quat_y; qb[5] = quat_z;
    qa[6] = quat_w; qb[6] = quat_x;
    qa[7] = quat_w; qb[7] = quat_y;
    qa[8] = quat_w; qb[8] = quat_z;
  end

  for (genvar k = 0; k < 9; k++) begin : g_qmul
    pprj_mul #(.AW(32), .BW(32)) u_mul (
      .clk(clk), .en(en), .a(qa[k]), .b(qb[k]), .p(qp[k])
    );
  end

  pprj_mul #(.AW(32), .BW(32)) u_gmul (
    .clk(clk), .en(en),
    .a($signed({1'b0, info_scale})), .b($signed({1'b0, wgt0})), .p(gp)
  );

  // stage 3: rotation matrix and scale
  logic signed [RW-1:0] r_next [3][3];
  logic signed [RW-1:0] r3 [3][3];
  logic signed [GW-1:0] g3;

  always_comb begin
    wide_t qq [9];
    wide_t one;
    for (int k = 0; k < 9; k++) begin
      qq[k] = rnd_clamp(wide_t'(qp[k]), U);
    end
    one = wide_t'(1) <<< U;
    r_next[0][0] = RW'(one - ((qq[1] + qq[2]) <<< 1));
    r_next[0][1] = RW'((qq[3] - qq[8]) <<< 1);
    r_next[0][2] = RW'((qq[4] + qq[7]) <<< 1);
    r_next[1][0] = RW'((qq[3] + qq[8]) <<< 1);
    r_next[1][1] = RW'(one - ((qq[0] + qq[2]) <<< 1));
    r_next[1][2] = RW'((qq[5] - qq[6]) <<< 1);
    r_next[2][0] = RW'((qq[4] - qq[7]) <<< 1);
    r_next[2][1] = RW'((qq[5] + qq[6]) <<< 1);
    r_next[2][2] = RW'(one - ((qq[0] + qq[1]) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= r_next;
      g3 <= GW'(rnd_clamp(wide_t'(gp), V));
    end
  end

  logic [2:0][31:0] p3, n3, p6, n6, n9;
  logic [31:0]      off8;
  logic [GW-1:0]    g9;

  pprj_dly #(.WIDTH(96), .DEPTH(3)) u_p3  (.clk(clk), .en(en), .din(p0), .dout(p3));
  pprj_dly #(.WIDTH(96), .DEPTH(3)) u_n3  (.clk(clk), .en(en), .din(n0), .dout(n3));
  pprj_dly #(.WIDTH(96), .DEPTH(3)) u_p6  (.clk(clk), .en(en), .din(p3), .dout(p6));
  pprj_dly #(.WIDTH(96), .DEPTH(3)) u_n6  (.clk(clk), .en(en), .din(n3), .dout(n6));
  pprj_dly #(.WIDTH(96), .DEPTH(3)) u_n9  (.clk(clk), .en(en), .din(n6), .dout(n9));
  pprj_dly #(.WIDTH(32), .DEPTH(8)) u_off (.clk(clk), .en(en), .din(off0), .dout(off8));
  pprj_dly #(.WIDTH(GW), .DEPTH(6)) u_g9  (.clk(clk), .en(en), .din(g3), .dout(g9));

  // stages 4-5: R*p and R^T*n
  logic signed [RW+31:0] rp [3][3];
  logic signed [RW+31:0] rn [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      pprj_mul #(.AW(RW), .BW(32)) u_rp (
        .clk(clk), .en(en), .a(r3[i][j]), .b($signed(p3[j])), .p(rp[i][j])
      );
      pprj_mul #(.AW(RW), .BW(32)) u_rn (
        .clk(clk), .en(en), .a(r3[i][j]), .b($signed(n3[i])), .p(rn[i][j])
      );
    end
  end

  // stage 6: world point and normal rotated by R^T
  logic signed [WW-1:0] w_next [3];
  logic signed [MW-1:0] m_next [3];
  logic signed [WW-1:0] w6 [3];
  logic signed [MW-1:0] m6 [3];

  always_comb begin
    wide_t acc;
    for (int i = 0; i < 3; i++) begin
      acc = wide_t'(trans[i]);
      for (int j = 0; j < 3; j++) begin
        acc = acc + rnd_clamp(wide_t'(rp[i][j]), U);
      end
      w_next[i] = WW'(clamp_wide(acc));
    end
    for (int j = 0; j < 3; j++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        acc = acc + rnd_clamp(wide_t'(rn[i][j]), U);
      end
      m_next[j] = MW'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w6 <= w_next;
      m6 <= m_next;
    end
  end

  // stages 7-8: n*world and cross product terms
  logic signed [WW+31:0] nw [3];
  logic signed [MW+31:0] pm [6];
  logic signed [MW-1:0]  pm_a [6];
  logic signed [31:0]    pm_b [6];

  always_comb begin
    pm_a[0] = m6[2]; pm_b[0] = $signed(p6[1]);
    pm_a[1] = m6[1]; pm_b[1] = $signed(p6[2]);
    pm_a[2] = m6[0]; pm_b[2] = $signed(p6[2]);
    pm_a[3] = m6[2]; pm_b[3] = $signed(p6[0]);
    pm_a[4] = m6[1]; pm_b[4] = $signed(p6[0]);
    pm_a[5] = m6[0]; pm_b[5] = $signed(p6[1]);
  end

  for (genvar i = 0; i < 3; i++) begin : g_nw
    pprj_mul #(.AW(WW), .BW(32)) u_nw (
      .clk(clk), .en(en), .a(w6[i]), .b($signed(n6[i])), .p(nw[i])
    );
  end

  for (genvar k = 0; k < 6; k++) begin : g_pm
    pprj_mul #(.AW(MW), .BW(32)) u_pm (
      .clk(clk), .en(en), .a(pm_a[k]), .b(pm_b[k]), .p(pm[k])
    );
  end

  // stage 9: distance and cross product
  logic signed [DW-1:0] d9;
  logic signed [CW-1:0] c9 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d9 <= DW'(wide_t'($signed(off8)) + rnd_clamp(wide_t'(nw[0]), U)
                + rnd_clamp(wide_t'(nw[1]), U) + rnd_clamp(wide_t'(nw[2]), U));
      for (int i = 0; i < 3; i++) begin
        c9[i] <= CW'(rnd_clamp(wide_t'(pm[2*i]), U) - rnd_clamp(wide_t'(pm[2*i+1]), U));
      end
    end
  end

  // stages 10-11: final scaling
  logic signed [GW+DW-1:0] gd;
  logic signed [GW+31:0]   gn [3];
  logic signed [GW+CW-1:0] gc [3];

  pprj_mul #(.AW(GW), .BW(DW)) u_gd (
    .clk(clk), .en(en), .a($signed(g9)), .b(d9), .p(gd)
  );

  for (genvar i = 0; i < 3; i++) begin : g_fin
    pprj_mul #(.AW(GW), .BW(32)) u_gn (
      .clk(clk), .en(en), .a($signed(g9)), .b($signed(n9[i])), .p(gn[i])
    );
    pprj_mul #(.AW(GW), .BW(CW)) u_gc (
      .clk(clk), .en(en), .a($signed(g9)), .b(c9[i]), .p(gc[i])
    );
  end

  // stage 12: round, saturate and hold for the consumer
  always_ff @(posedge clk) begin
    if (en) begin
      residual    <= sat32(rnd_shift(wide_t'(gd), V));
      jac_trans_x <= sat32(rnd_shift(wide_t'(gn[0]), U));
      jac_trans_y <= sat32(rnd_shift(wide_t'(gn[1]), U));
      jac_trans_z <= sat32(rnd_shift(wide_t'(gn[2]), U));
      jac_rot_x   <= sat32(rnd_shift(wide_t'(gc[0]), V));
      jac_rot_y   <= sat32(rnd_shift(wide_t'(gc[1]), V));
      jac_rot_z   <= sat32(rnd_shift(wide_t'(gc[2]), V));
    end
  end

  ap_stall_back: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> point_stall)
    else $error("point channel open while result is stalled");

  ap_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  ap_freeze: assert property (@(posedge clk) disable iff (rst)
    (!en && !$past(rst)) |=> $stable(vld))
    else $error("pipeline moved while frozen");

  ap_enter: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall) |=> vld[0])
    else $error("accepted item lost at entry");

endmodule
